### rtl/ttes_pkg.sv
// ----------------------------------------------------------------------------
// ttes_pkg
// Shared types, register codes and the code point decoder of the scanner.
// ----------------------------------------------------------------------------
package ttes_pkg;

  localparam int WINDOW_BYTES   = 4;
  localparam int FILL_W         = $clog2(WINDOW_BYTES + 1);
  localparam int DEF_CNT_BITS   = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int PT_W           = 21;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_MAX_BYTES = 2'd1;
  localparam logic [1:0] REG_DBL       = 2'd2;

  localparam logic [2:0] MODE_RAW   = 3'd0;
  localparam logic [2:0] MODE_UTF8  = 3'd1;
  localparam logic [2:0] MODE_U16LE = 3'd2;
  localparam logic [2:0] MODE_U16BE = 3'd3;
  localparam logic [2:0] MODE_SJIS  = 3'd4;

  localparam logic [2:0]  RST_MODE      = MODE_UTF8;
  localparam logic [15:0] RST_MAX_BYTES = 16'd16000;

  typedef struct packed {
    logic [FILL_W-1:0] used;
    logic              ok;
    logic [PT_W-1:0]   point;
  } ttes_dec_t;

  // One entry of the front-to-back queue: a classified point or end of stream
  typedef struct packed {
    logic        fin;
    logic [15:0] consumed;
    logic        ok;
    logic        is_cr;
    logic        lf;
    logic        ctl;
    logic        nul;
    logic        plain;
    logic        space;
    logic        ext;
    logic        dbl;
  } ttes_evt_t;

  function automatic ttes_dec_t ttes_decode(input logic [WINDOW_BYTES-1:0][7:0] w,
                                            input logic [FILL_W-1:0] n,
                                            input logic [2:0] mode);
    ttes_dec_t   d;
    logic [15:0] u0;
    logic [15:0] u1;
    logic        c1;
    logic        c2;
    logic        c3;
    d.used  = FILL_W'(1);
    d.ok    = 1'b0;
    d.point = PT_W'(w[0]);
    c1 = (w[1][7:6] == 2'b10);
    c2 = (w[2][7:6] == 2'b10);
    c3 = (w[3][7:6] == 2'b10);
    u0 = (mode == MODE_U16BE) ? {w[0], w[1]} : {w[1], w[0]};
    u1 = (mode == MODE_U16BE) ? {w[2], w[3]} : {w[3], w[2]};
    case (mode)
      MODE_UTF8: begin
        if (!w[0][7]) begin
          d.ok = 1'b1;
        end else if (w[0][7:5] == 3'b110) begin
          if (n >= FILL_W'(2) && c1) begin
            d.ok = 1'b1; d.used = FILL_W'(2);
            d.point = PT_W'({w[0][4:0], w[1][5:0]});
          end
        end else if (w[0][7:4] == 4'hE) begin
          if (n >= FILL_W'(3) && c1 && c2) begin
            d.ok = 1'b1; d.used = FILL_W'(3);
            d.point = PT_W'({w[0][3:0], w[1][5:0], w[2][5:0]});
          end
        end else if (w[0][7:3] == 5'b11110) begin
          if (n >= FILL_W'(4) && c1 && c2 && c3) begin
            d.ok = 1'b1; d.used = FILL_W'(4);
            d.point = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
          end
        end
      end
      MODE_U16LE, MODE_U16BE: begin
        d.point = PT_W'(u0);
        d.used  = FILL_W'(2);
        if (n < FILL_W'(2)) begin
          d.used = '0;
        end else if (u0[15:10] == 6'b110110) begin
          if (n >= FILL_W'(4) && u1[15:10] == 6'b110111) begin
            d.ok = 1'b1; d.used = FILL_W'(4);
            d.point = PT_W'(21'h10000 + PT_W'({u0[9:0], u1[9:0]}));
          end
        end else if (u0[15:10] != 6'b110111) begin
          d.ok = 1'b1;
        end
      end
      MODE_SJIS: begin
        if (w[0] < 8'h7F) begin
          d.ok = 1'b1;
        end else if (n >= FILL_W'(2) &&
                     ((w[0] >= 8'h81 && w[0] <= 8'h9F) || (w[0] >= 8'hE0 && w[0] <= 8'hEF)) &&
                     ((w[1] >= 8'h40 && w[1] <= 8'h7E) || (w[1] >= 8'h80 && w[1] <= 8'hFC))) begin
          d.ok = 1'b1; d.used = FILL_W'(2);
          d.point = PT_W'({w[0], w[1]});
        end
      end
      default: begin
        d.ok = 1'b1;
      end
    endcase
    if (n == '0) d.used = '0;
    return d;
  endfunction

endpackage

### rtl/ttes_front.sv
// ----------------------------------------------------------------------------
// ttes_front
// Lookahead window, decoder, classifier and end-of-stream flush sequencer.
// ----------------------------------------------------------------------------
module ttes_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last,
  input  logic [2:0]        mode,
  input  logic [15:0]       max_bytes,
  input  logic              count_dbl,
  input  logic              q_full,
  output logic              push,
  output ttes_pkg::ttes_evt_t push_evt
);
  import ttes_pkg::*;

  typedef enum logic {ST_RUN, ST_FLUSH} state_t;

  state_t                       state_r, state_nxt;
  logic [WINDOW_BYTES-1:0][7:0] win_r, win_nxt, win_ins, dwin;
  logic [FILL_W-1:0]            fill_r, fill_nxt, fill_ins, dfill;
  logic [15:0]                  cons_r, cons_nxt;
  logic [16:0]                  cons_sum;
  logic                         stop_r, stop_nxt;
  logic                         do_dec;
  ttes_dec_t                    dec;
  logic                         pt_ok;

  assign in_ready = (state_r == ST_RUN) && !q_full;

  always_comb begin
    win_ins  = win_r;
    fill_ins = fill_r;
    if (!stop_r && fill_r < FILL_W'(WINDOW_BYTES)) begin
      win_ins[fill_r[FILL_W-2:0]] = in_data_byte;
      fill_ins = fill_r + FILL_W'(1);
    end
  end

  always_comb begin
    if (state_r == ST_RUN) begin
      dwin   = win_ins;
      dfill  = fill_ins;
      do_dec = in_valid && in_ready && !stop_r && fill_ins == FILL_W'(WINDOW_BYTES);
    end else begin
      dwin   = win_r;
      dfill  = fill_r;
      do_dec = !q_full && !stop_r && fill_r != '0;
    end
  end

  assign dec      = ttes_decode(dwin, dfill, mode);
  assign cons_sum = {1'b0, cons_r} + 17'(dec.used);

  always_comb begin
    state_nxt = state_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    cons_nxt  = cons_r;
    stop_nxt  = stop_r;
    push      = 1'b0;
    pt_ok     = 1'b0;
    if (state_r == ST_RUN && in_valid && in_ready) begin
      win_nxt  = win_ins;
      fill_nxt = fill_ins;
      if (in_last) state_nxt = ST_FLUSH;
    end
    if (do_dec) begin
      if (cons_r >= max_bytes || dec.used == '0) begin
        stop_nxt = 1'b1;
      end else begin
        push     = 1'b1;
        pt_ok    = dec.ok;
        cons_nxt = cons_sum[16] ? 16'hFFFF : cons_sum[15:0];
        win_nxt  = dwin >> {dec.used, 3'b000};
        fill_nxt = dfill - dec.used;
      end
    end else if (state_r == ST_FLUSH && !q_full) begin
      // window drained or scan stopped: send end marker, clear stream
      push      = 1'b1;
      state_nxt = ST_RUN;
      fill_nxt  = '0;
      cons_nxt  = '0;
      stop_nxt  = 1'b0;
    end
  end

  always_comb begin
    push_evt          = '0;
    push_evt.fin      = !do_dec;
    push_evt.consumed = cons_r;
    push_evt.ok       = pt_ok;
    push_evt.is_cr    = dec.point == PT_W'(13);
    if (pt_ok) begin
      if (dec.point < PT_W'(32)) begin
        push_evt.lf    = dec.point == PT_W'(10);
        push_evt.plain = dec.point == PT_W'(10) || dec.point == PT_W'(9) ||
                         dec.point == PT_W'(13);
        push_evt.space = dec.point == PT_W'(10) || dec.point == PT_W'(9);
        push_evt.ctl   = !push_evt.plain;
        push_evt.nul   = dec.point == '0;
      end else if (dec.point < PT_W'(127)) begin
        push_evt.plain = 1'b1;
        push_evt.space = dec.point == PT_W'(32);
      end else if (dec.point >= PT_W'(21'h10000)) begin
        push_evt.ext = 1'b1;
      end else begin
        push_evt.dbl = count_dbl && dec.point >= PT_W'(21'h8140);
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      state_r <= ST_RUN;
      fill_r  <= '0;
      cons_r  <= '0;
      stop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cons_r  <= cons_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

### rtl/ttes_queue.sv
// ----------------------------------------------------------------------------
// ttes_queue
// Short FIFO of classified points between the front and the back.
// ----------------------------------------------------------------------------
module ttes_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ttes_pkg::ttes_evt_t push_evt,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output ttes_pkg::ttes_evt_t head
);
  import ttes_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  ttes_evt_t     mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = cnt_r == (AW+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop)  rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

### rtl/ttes_back.sv
// ----------------------------------------------------------------------------
// ttes_back
// Saturating statistics counters and the result register.
// ----------------------------------------------------------------------------
module ttes_back #(
  parameter int COUNTER_BITS = ttes_pkg::DEF_CNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ttes_pkg::ttes_evt_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_bytes_consumed,
  output logic [15:0]         out_num_points,
  output logic [15:0]         out_num_invalid,
  output logic [15:0]         out_num_lines,
  output logic [15:0]         out_num_crlf,
  output logic [15:0]         out_num_control,
  output logic [15:0]         out_num_null,
  output logic [15:0]         out_num_plain_ascii,
  output logic [15:0]         out_num_whitespace,
  output logic [15:0]         out_num_extended,
  output logic [15:0]         out_num_double_byte,
  output logic                out_crlf_majority
);
  import ttes_pkg::*;

  localparam int CB = COUNTER_BITS;
  localparam int NC = 10;
  localparam int C_PT = 0, C_OK = 1, C_LF = 2, C_CRLF = 3, C_CTL = 4;
  localparam int C_NUL = 5, C_PL = 6, C_SP = 7, C_EXT = 8, C_DBL = 9;

  logic [CB-1:0] cnt_r [NC];
  logic [NC-1:0] inc;
  logic          prev_cr_r;
  logic          out_valid_r;
  logic          load;
  logic [CB:0]   crlf2;

  function automatic logic [15:0] clip(input logic [CB-1:0] v);
    return (v > CB'(16'hFFFF)) ? 16'hFFFF : v[15:0];
  endfunction

  assign out_valid = out_valid_r;
  // only the end marker waits for the result register; points keep counting
  assign pop  = !q_empty && (!head.fin || !out_valid_r || out_ready);
  assign load = pop && head.fin;
  assign crlf2 = {cnt_r[C_CRLF], 1'b0};

  always_comb begin
    inc        = '0;
    inc[C_PT]  = 1'b1;
    inc[C_OK]  = head.ok;
    inc[C_LF]  = head.lf;
    inc[C_CRLF]= head.lf && prev_cr_r;
    inc[C_CTL] = head.ctl;
    inc[C_NUL] = head.nul;
    inc[C_PL]  = head.plain;
    inc[C_SP]  = head.space;
    inc[C_EXT] = head.ext;
    inc[C_DBL] = head.dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) cnt_r[i] <= '0;
      prev_cr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        // snapshot into result register, clear for the next stream
        for (int i = 0; i < NC; i++) cnt_r[i] <= '0;
        prev_cr_r   <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (out_ready) out_valid_r <= 1'b0;
        if (pop) begin
          for (int i = 0; i < NC; i++) begin
            if (inc[i] && cnt_r[i] != '1) cnt_r[i] <= cnt_r[i] + CB'(1);
          end
          prev_cr_r <= head.is_cr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_bytes_consumed  <= head.consumed;
      out_num_points      <= clip(cnt_r[C_PT]);
      out_num_invalid     <= clip(cnt_r[C_PT] - cnt_r[C_OK]);
      out_num_lines       <= clip(cnt_r[C_LF]);
      out_num_crlf        <= clip(cnt_r[C_CRLF]);
      out_num_control     <= clip(cnt_r[C_CTL]);
      out_num_null        <= clip(cnt_r[C_NUL]);
      out_num_plain_ascii <= clip(cnt_r[C_PL]);
      out_num_whitespace  <= clip(cnt_r[C_SP]);
      out_num_extended    <= clip(cnt_r[C_EXT]);
      out_num_double_byte <= clip(cnt_r[C_DBL]);
      out_crlf_majority   <= (cnt_r[C_CRLF] != '0) && (crlf2 >= {1'b0, cnt_r[C_LF]});
    end
  end

endmodule

### rtl/text_encoding_stats_scanner.sv
// ----------------------------------------------------------------------------
// text_encoding_stats_scanner
// Byte stream decoder and text statistics counter with APB configuration.
// ----------------------------------------------------------------------------
// While the queue has room and no flush runs, takes one byte per cycle into a
// four-byte lookahead window; whenever the window fills, the single shared
// decoder decodes one code point in the selected encoding and its class is
// queued to the counter stage, so ordinary bytes then stream at one item per
// clock. The item flagged last starts a flush: no new item is taken while the
// window drains through the same decoder, one point per cycle while the queue
// has room, then queues the end marker, which loads the output register once
// the entries ahead of it are counted and any earlier result was taken; the
// next stream may start meanwhile. A four-entry queue parts the decoder from
// the counters, so a stalled result only halts input once it fills.
// Registers: 0x0 mode, 0x4 max_bytes, 0x8 count_double_byte.
// ----------------------------------------------------------------------------
module text_encoding_stats_scanner #(
  parameter int COUNTER_BITS = ttes_pkg::DEF_CNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_bytes_consumed,
  output logic [15:0] out_num_points,
  output logic [15:0] out_num_invalid,
  output logic [15:0] out_num_lines,
  output logic [15:0] out_num_crlf,
  output logic [15:0] out_num_control,
  output logic [15:0] out_num_null,
  output logic [15:0] out_num_plain_ascii,
  output logic [15:0] out_num_whitespace,
  output logic [15:0] out_num_extended,
  output logic [15:0] out_num_double_byte,
  output logic        out_crlf_majority
);
  import ttes_pkg::*;

  logic [2:0]  mode_r;
  logic [15:0] max_r;
  logic        dbl_r;
  logic        wr;
  logic        push, pop, q_full, q_empty;
  ttes_evt_t   push_evt, head;

  // configuration: zero wait states, writes on the access phase
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_MODE:      prdata = {29'd0, mode_r};
      REG_MAX_BYTES: prdata = {16'd0, max_r};
      REG_DBL:       prdata = {31'd0, dbl_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RST_MODE;
      max_r  <= RST_MAX_BYTES;
      dbl_r  <= 1'b0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_MODE:      mode_r <= pwdata[2:0];
        REG_MAX_BYTES: max_r  <= pwdata[15:0];
        REG_DBL:       dbl_r  <= pwdata[0];
        default:       ;
      endcase
    end
  end

  // front: window, decode and flush
  ttes_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_last,
    .mode(mode_r), .max_bytes(max_r), .count_dbl(dbl_r),
    .q_full, .push, .push_evt
  );

  ttes_queue u_queue (
    .clk, .rst_n, .push, .push_evt, .full(q_full), .pop, .empty(q_empty), .head
  );

  // back: counters and result register
  ttes_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk, .rst_n, .q_empty, .head, .pop, .out_valid, .out_ready,
    .out_bytes_consumed, .out_num_points, .out_num_invalid, .out_num_lines,
    .out_num_crlf, .out_num_control, .out_num_null, .out_num_plain_ascii,
    .out_num_whitespace, .out_num_extended, .out_num_double_byte,
    .out_crlf_majority
  );

endmodule

### rtl/ttes_checker.sv
// ----------------------------------------------------------------------------
// ttes_checker
// Port-level checks on the scanner results.
// ----------------------------------------------------------------------------
module ttes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_num_points,
  input logic [15:0] out_num_invalid,
  input logic [15:0] out_num_lines,
  input logic [15:0] out_num_crlf,
  input logic [15:0] out_num_control,
  input logic [15:0] out_num_null,
  input logic        out_crlf_majority
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_num_points))
    else $error("result dropped or changed while stalled");

  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_num_invalid <= out_num_points)
    else $error("more invalid points than points");

  a_crlf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_num_crlf <= out_num_lines)
    else $error("more CRLFs than lines");

  a_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_num_null <= out_num_control)
    else $error("null count exceeds control count");

  a_maj: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crlf_majority |-> out_num_crlf != 16'd0)
    else $error("CRLF majority without any CRLF");

endmodule

bind text_encoding_stats_scanner ttes_checker u_ttes_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_num_points, .out_num_invalid,
  .out_num_lines, .out_num_crlf, .out_num_control, .out_num_null,
  .out_crlf_majority
);

### dv/tb_text_encoding_stats_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_encoding_stats_scanner
// Self-checking bench for the text statistics scanner.
// ----------------------------------------------------------------------------
// A short table of directed streams runs under the reset configuration. It is
// followed by phases of random streams that cover every encoding, the byte
// limit and both settings of double-byte counting. Each accepted item steps an
// internal model of the decoder. A last item queues the expected counts, and
// each result taken from the block is checked against the oldest entry.
// ----------------------------------------------------------------------------
module tb_text_encoding_stats_scanner;
  import ttes_pkg::*;

  localparam int CNT_MAX    = 65535;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [15:0] consumed;
    logic [15:0] points;
    logic [15:0] invalid;
    logic [15:0] lines;
    logic [15:0] crlf;
    logic [15:0] control;
    logic [15:0] nul;
    logic [15:0] plain;
    logic [15:0] space;
    logic [15:0] ext;
    logic [15:0] dbl;
    logic        majority;
  } stats_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    stats_t     stats;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  wire stats_t got;

  text_encoding_stats_scanner u_top (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_bytes_consumed(got.consumed), .out_num_points(got.points),
    .out_num_invalid(got.invalid), .out_num_lines(got.lines),
    .out_num_crlf(got.crlf), .out_num_control(got.control),
    .out_num_null(got.nul), .out_num_plain_ascii(got.plain),
    .out_num_whitespace(got.space), .out_num_extended(got.ext),
    .out_num_double_byte(got.dbl), .out_crlf_majority(got.majority)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scanner model: configuration and per-stream state
  logic [2:0]  cur_mode;
  int unsigned cur_max;
  bit          cur_dbl;
  logic [7:0]  win [WINDOW_BYTES];
  int          fill;
  int unsigned n_cons, n_pts, n_ok, n_lf, n_crlf, n_ctl, n_nul;
  int unsigned n_plain, n_sp, n_ext, n_dbl;
  bit          last_cr, halted;

  stats_t      stats_q[$];
  int          errors = 0;
  int          in_pct = 0;
  int          out_pct = 0;
  int          idle_run = 0;

  function automatic void bump(ref int unsigned c);
    if (c < CNT_MAX) c++;
  endfunction

  function automatic void clear_stream();
    fill = 0; n_cons = 0; n_pts = 0; n_ok = 0; n_lf = 0; n_crlf = 0;
    n_ctl = 0; n_nul = 0; n_plain = 0; n_sp = 0; n_ext = 0; n_dbl = 0;
    last_cr = 0; halted = 0;
    foreach (win[i]) win[i] = '0;
  endfunction

  function automatic bit in_rng(int unsigned v, int unsigned lo, int unsigned hi);
    return v >= lo && v <= hi;
  endfunction

  // Decode one point from the window front; zero bytes used means stuck
  function automatic int front_point(output int unsigned pt, output bit ok);
    int unsigned b0, need, lead, u0, u1;
    b0 = win[0]; pt = b0; ok = 0;
    if (fill == 0) return 0;
    case (cur_mode)
      MODE_UTF8: begin
        if (b0 < 'h80) begin ok = 1; return 1; end
        if (in_rng(b0, 'hC0, 'hDF)) begin need = 1; lead = b0 & 'h1F; end
        else if (in_rng(b0, 'hE0, 'hEF)) begin need = 2; lead = b0 & 'h0F; end
        else if (in_rng(b0, 'hF0, 'hF7)) begin need = 3; lead = b0 & 'h07; end
        else return 1;
        if (fill < need + 1) return 1;
        pt = lead;
        for (int i = 1; i <= need; i++) begin
          if ((win[i] & 8'hC0) != 8'h80) begin pt = b0; return 1; end
          pt = (pt << 6) | (win[i] & 8'h3F);
        end
        ok = 1;
        return need + 1;
      end
      MODE_U16LE, MODE_U16BE: begin
        if (fill < 2) return 0;
        u0 = (cur_mode == MODE_U16BE) ? {win[0], win[1]} : {win[1], win[0]};
        pt = u0;
        if (in_rng(u0, 'hD800, 'hDBFF)) begin
          if (fill < 4) return 2;
          u1 = (cur_mode == MODE_U16BE) ? {win[2], win[3]} : {win[3], win[2]};
          if (in_rng(u1, 'hDC00, 'hDFFF)) begin
            pt = 'h10000 + ((u0 - 'hD800) << 10) + (u1 - 'hDC00);
            ok = 1;
            return 4;
          end
          return 2;
        end
        ok = !in_rng(u0, 'hDC00, 'hDFFF);
        return 2;
      end
      MODE_SJIS: begin
        if (b0 < 'h7F) begin ok = 1; return 1; end
        if (fill < 2) return 1;
        if ((in_rng(b0, 'h81, 'h9F) || in_rng(b0, 'hE0, 'hEF)) &&
            (in_rng(win[1], 'h40, 'h7E) || in_rng(win[1], 'h80, 'hFC))) begin
          pt = (b0 << 8) | win[1];
          ok = 1;
          return 2;
        end
        return 1;
      end
      default: begin
        ok = 1;
        return 1;
      end
    endcase
  endfunction

  function automatic void tally(int unsigned p, bit ok);
    bump(n_pts);
    if (ok) begin
      bump(n_ok);
      if (p < 32) begin
        if (p == 10) begin
          bump(n_plain); bump(n_lf); bump(n_sp);
          if (last_cr) bump(n_crlf);
        end else if (p == 9) begin
          bump(n_plain); bump(n_sp);
        end else if (p == 13) begin
          bump(n_plain);
        end else begin
          bump(n_ctl);
          if (p == 0) bump(n_nul);
        end
      end else if (p < 127) begin
        bump(n_plain);
        if (p == 32) bump(n_sp);
      end else if (p >= 'h10000) begin
        bump(n_ext);
      end else if (cur_dbl && p >= 'h8140) begin
        bump(n_dbl);
      end
    end
    last_cr = (p == 13);
  endfunction

  function automatic void decode_step();
    int unsigned p;
    bit ok;
    int used;
    if (n_cons >= cur_max) begin halted = 1; return; end
    used = front_point(p, ok);
    if (used == 0 || used > fill) begin halted = 1; return; end
    n_cons = (n_cons + used > CNT_MAX) ? CNT_MAX : n_cons + used;
    tally(p, ok);
    for (int i = 0; i < WINDOW_BYTES; i++)
      win[i] = (i + used < WINDOW_BYTES) ? win[i + used] : 8'h00;
    fill -= used;
  endfunction

  // Step the model by one accepted item; returns 1 when a result is due
  function automatic bit scan_byte(logic [7:0] b, logic lst, output stats_t s);
    s = '0;
    if (!halted && fill < WINDOW_BYTES) begin win[fill] = b; fill++; end
    if (!halted && fill == WINDOW_BYTES) decode_step();
    if (!lst) return 0;
    while (!halted && fill > 0) decode_step();
    s = '{16'(n_cons), 16'(n_pts), 16'(n_pts - n_ok), 16'(n_lf), 16'(n_crlf),
          16'(n_ctl), 16'(n_nul), 16'(n_plain), 16'(n_sp), 16'(n_ext),
          16'(n_dbl), (n_crlf != 0 && 2 * n_crlf >= n_lf)};
    clear_stream();
    return 1;
  endfunction

  // Result side: random stall, check against the oldest expectation
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_pct);
    if (out_valid && out_ready) begin
      if (stats_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        stats_t want;
        want = stats_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing is accepted on either channel and no register access is open
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("text_encoding_stats_scanner test failed");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE:      cur_mode = val[2:0];
      REG_MAX_BYTES: cur_max = val[15:0];
      default:       cur_dbl = val[0];
    endcase
  endtask

  // Drain: drop valid, wait for all expected results, then let the flush settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (stats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Offer one item, hold it until accepted, then step the model
  task automatic send(logic [7:0] b, logic lst, bit typed, stats_t typed_stats);
    stats_t s;
    while ($urandom_range(99) < in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_data_byte <= b; in_last <= lst;
    // ready depends only on registered state: sample it between edges, then take the accepting edge
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (scan_byte(b, lst, s)) stats_q.push_back(typed ? typed_stats : s);
  endtask

  // Append one stream of mostly well-formed text in the current encoding
  task automatic build_stream(ref logic [7:0] bq[$]);
    int len;
    int unsigned cp;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(12, 1);
    for (int k = 0; k < len; k++) begin
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
        bq.push_back(8'($urandom));
      end else if (pick <= 2) begin
        bq.push_back($urandom_range(1) ? 8'h0D : 8'h0A);
      end else begin
        case (cur_mode)
          MODE_UTF8: begin
            case ($urandom_range(3))
              0: bq.push_back(8'($urandom_range(127)));
              1: begin
                bq.push_back(8'(8'hC0 | $urandom_range(31)));
                bq.push_back(8'(8'h80 | $urandom_range(63)));
              end
              2: begin
                bq.push_back(8'(8'hE0 | $urandom_range(15)));
                bq.push_back(8'(8'h80 | $urandom_range(63)));
                bq.push_back(8'(8'h80 | $urandom_range(63)));
              end
              default: begin
                bq.push_back(8'(8'hF0 | $urandom_range(7)));
                repeat (3) bq.push_back(8'(8'h80 | $urandom_range(63)));
              end
            endcase
          end
          MODE_U16LE, MODE_U16BE: begin
            case ($urandom_range(3))
              0: cp = $urandom_range(127);
              1: cp = $urandom_range(16'hFFFF);
              2: cp = 'hDC00 | $urandom_range(1023);
              default: cp = ('hD800 | $urandom_range(1023)) << 16 |
                            ($urandom_range(7) != 0 ? 'hDC00 : 'h0000) | $urandom_range(1023);
            endcase
            for (int h = (cp > 'hFFFF) ? 1 : 0; h >= 0; h--) begin
              logic [15:0] u;
              u = 16'(cp >> (16 * h));
              if (cur_mode == MODE_U16BE) begin
                bq.push_back(u[15:8]); bq.push_back(u[7:0]);
              end else begin
                bq.push_back(u[7:0]); bq.push_back(u[15:8]);
              end
            end
          end
          MODE_SJIS: begin
            if ($urandom_range(1)) begin
              bq.push_back(8'($urandom_range(127)));
            end else begin
              bq.push_back($urandom_range(1) ? 8'($urandom_range('h9F, 'h81))
                                             : 8'($urandom_range('hEF, 'hE0)));
              bq.push_back(8'($urandom_range('hFF, 'h3F)));
            end
          end
          default: bq.push_back(8'($urandom));
        endcase
      end
    end
  endtask

  // Directed streams under the reset setting (UTF-8, double-byte off)
  row_t dir_rows[] = '{
    '{8'h41, 1'b1, 1'b1, '{16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                          16'd1, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0,
                          16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{8'h00, 1'b1, 1'b1, '{16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1,
                          16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{8'h0D, 1'b0, 1'b0, '0}, '{8'h0A, 1'b0, 1'b0, '0},
    '{8'h09, 1'b0, 1'b0, '0}, '{8'h20, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b1, 1'b0, '0},
    '{8'hC3, 1'b0, 1'b0, '0}, '{8'hA9, 1'b0, 1'b0, '0},
    '{8'hE2, 1'b0, 1'b0, '0}, '{8'h82, 1'b0, 1'b0, '0}, '{8'hAC, 1'b0, 1'b0, '0},
    '{8'hF0, 1'b0, 1'b0, '0}, '{8'h9F, 1'b0, 1'b0, '0}, '{8'h98, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'hE2, 1'b0, 1'b0, '0}, '{8'h82, 1'b1, 1'b0, '0},
    '{8'hF8, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
    '{8'h1B, 1'b0, 1'b0, '0}, '{8'h0A, 1'b1, 1'b0, '0}
  };

  initial begin
    logic [7:0] bq[$];
    cur_mode = RST_MODE; cur_max = RST_MAX_BYTES; cur_dbl = 0;
    clear_stream();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].stats);
    drain();

    // Random phases: walk every encoding and an unassigned mode value, limits and both stall sides
    for (int ph = 0; ph < 12; ph++) begin
      int sent;
      in_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 8 : 76) : 0;
      out_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 8 : 76) : 0;
      reg_write(REG_MODE, (ph < 10) ? ph % 5 : 5 + ph % 3 + (ph == 11));
      case (ph % 6)
        0:       reg_write(REG_MAX_BYTES, 0);
        1:       reg_write(REG_MAX_BYTES, 65532);
        2, 4:    reg_write(REG_MAX_BYTES, $urandom_range(8, 1));
        default: reg_write(REG_MAX_BYTES, RST_MAX_BYTES);
      endcase
      reg_write(REG_DBL, ph % 2);
      sent = 0;
      while (sent < 115) begin
        bq.delete();
        build_stream(bq);
        foreach (bq[k]) send(bq[k], k == bq.size() - 1, 1'b0, '0);
        sent += bq.size();
      end
      drain();
    end

    if (errors == 0) begin
      $display("text_encoding_stats_scanner test passed");
    end else begin
      $display("text_encoding_stats_scanner test failed");
    end
    $finish;
  end

endmodule

### text_encoding_stats_scanner.f
rtl/ttes_pkg.sv
rtl/ttes_front.sv
rtl/ttes_queue.sv
rtl/ttes_back.sv
rtl/text_encoding_stats_scanner.sv
rtl/ttes_checker.sv
dv/tb_text_encoding_stats_scanner.sv
